// File: rtl/bpa_pkg.sv
// Shared types, constants and small helper functions for the buddy page allocator.
// No dependencies; the allocator and the testbench import this package.
package bpa_pkg;

   localparam int NUM_PAGES = 4096;
   localparam int MAX_ORDER = 12;
   localparam int PAGE_W    = 12;
   localparam int LINK_W    = 13;
   localparam int ORD_W     = 4;
   localparam int ST_W      = 2;

   localparam logic [LINK_W-1:0] NIL = LINK_W'(NUM_PAGES);

   localparam logic [ST_W-1:0] ST_UNUSED = 2'd0;
   localparam logic [ST_W-1:0] ST_FREE   = 2'd1;
   localparam logic [ST_W-1:0] ST_ALLOC  = 2'd2;
   localparam logic [ST_W-1:0] ST_RESV   = 2'd3;

   localparam logic [1:0] ACT_INIT  = 2'd0;
   localparam logic [1:0] ACT_ALLOC = 2'd1;
   localparam logic [1:0] ACT_FREE  = 2'd2;
   localparam logic [1:0] ACT_RESV  = 2'd3;

   // status and order of one block head
   typedef struct packed {
      logic [ST_W-1:0]  st;
      logic [ORD_W-1:0] ord;
   } so_type;

   function automatic logic [LINK_W-1:0] span_of(input logic [ORD_W-1:0] o);
      span_of = LINK_W'(1) << o;
   endfunction

   // clear the low k bits of a page index
   function automatic logic [PAGE_W-1:0] align_mask(input logic [ORD_W-1:0] k);
      align_mask = ~((PAGE_W'(1) << k) - PAGE_W'(1));
   endfunction

   // largest aligned block that fits at pg with left pages remaining
   function automatic logic [ORD_W-1:0] carve_order(input logic [LINK_W-1:0] pg,
                                                    input logic [LINK_W-1:0] left);
      logic [ORD_W-1:0] hi;
      logic [ORD_W-1:0] tz;
      hi = '0;
      tz = ORD_W'(MAX_ORDER);
      for (int i = 0; i <= MAX_ORDER; i++) begin
         if (left[i]) hi = ORD_W'(i);
      end
      for (int i = MAX_ORDER; i >= 0; i--) begin
         if (pg[i]) tz = ORD_W'(i);
      end
      carve_order = (hi < tz) ? hi : tz;
   endfunction

endpackage

// File: rtl/bpa_ram.sv
// Single-port synchronous RAM with registered read data, one access per cycle.
// No package dependencies.
module bpa_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      // hold read data until the next read
      if (re) rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/buddy_page_allocator.sv
// Buddy page allocator top level: sequencer over the status/order and link RAMs.
// Depends on bpa_pkg and bpa_ram.
//
//   channel   ports                                        flow
//   request   start, busy, req_action, req_page            taken when start && !busy
//   response  rsp_valid, rsp_status, rsp_page_out,         one-cycle strobe, no backpressure
//             rsp_free_count
//   config    csr_valid, csr_ready, csr_wdata              written when valid && ready
//
// Init runs a clearing sweep of the status/order RAM, one entry a cycle, then carves
// the pool into free blocks; allocate, free and reserve take one RAM access per step
// of the split or merge walk and of the owner search.
// Reset runs the same clearing sweep with busy high and no response.
// The receiver cannot stall: the response is shown for one cycle, then busy drops.
module buddy_page_allocator (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_action,
   input  logic [bpa_pkg::PAGE_W-1:0]   req_page,
   output logic                         rsp_valid,
   output logic                         rsp_status,
   output logic [bpa_pkg::PAGE_W-1:0]   rsp_page_out,
   output logic [bpa_pkg::LINK_W-1:0]   rsp_free_count,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [bpa_pkg::LINK_W-1:0]   csr_wdata
);
   import bpa_pkg::*;

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_CLEAR  = 5'd1;
   localparam logic [4:0] S_CARVE  = 5'd2;
   localparam logic [4:0] S_PUSHA  = 5'd3;
   localparam logic [4:0] S_PUSHB  = 5'd4;
   localparam logic [4:0] S_POPW   = 5'd5;
   localparam logic [4:0] S_PIN0   = 5'd6;
   localparam logic [4:0] S_SCANR  = 5'd7;
   localparam logic [4:0] S_SCAND  = 5'd8;
   localparam logic [4:0] S_SPLIT  = 5'd9;
   localparam logic [4:0] S_TAKE   = 5'd10;
   localparam logic [4:0] S_TSPLIT = 5'd11;
   localparam logic [4:0] S_GIVE0  = 5'd12;
   localparam logic [4:0] S_GIVE1  = 5'd13;
   localparam logic [4:0] S_MCHK   = 5'd14;
   localparam logic [4:0] S_MCHD   = 5'd15;
   localparam logic [4:0] S_RESP   = 5'd16;

   // sequencer registers
   logic [4:0]        state_ff, state_in;
   logic [4:0]        ret_ff, ret_in;      // where a push returns to
   logic [1:0]        act_ff, act_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic [PAGE_W-1:0] cur_ff, cur_in;      // head of the block being walked
   logic [ORD_W-1:0]  ord_ff, ord_in;
   logic [PAGE_W-1:0] addr_ff, addr_in;    // entry whose links were read
   logic [ORD_W-1:0]  k_ff, k_in;          // owner search level
   logic [LINK_W-1:0] cnt_ff, cnt_in;      // clear index, then carve page
   logic [LINK_W-1:0] left_ff, left_in;
   logic [PAGE_W-1:0] x_ff, x_in;          // block being pushed
   logic [ORD_W-1:0]  po_ff, po_in;        // its order
   logic [LINK_W-1:0] hd_ff, hd_in;        // old list head behind it
   logic [LINK_W-1:0] free_ff, free_in;
   logic              fail_ff, fail_in;
   logic [PAGE_W-1:0] pout_ff, pout_in;
   logic [LINK_W-1:0] total_ff;
   logic [LINK_W-1:0] lh_ff [MAX_ORDER+1];
   logic [LINK_W-1:0] lh_in [MAX_ORDER+1];

   // RAM ports
   logic              so_we, so_re, nl_we, nl_re, pl_we, pl_re;
   logic [PAGE_W-1:0] so_addr, nl_addr, pl_addr;
   so_type            so_wdata, so_q;
   logic [$bits(so_type)-1:0] so_rd;
   logic [LINK_W-1:0] nl_wdata, pl_wdata, nl_q, pl_q;

   // datapath helpers
   logic [LINK_W-1:0] pool;
   logic [ORD_W-1:0]  child;
   logic [LINK_W-1:0] sp_ord, sp_child, sp_po, sp_carve;
   logic [ORD_W-1:0]  carve_o;
   logic [PAGE_W-1:0] mid, bud, scan_addr;
   logic              take_hit;
   logic [ORD_W-1:0]  take_o;

   assign pool      = (total_ff > LINK_W'(NUM_PAGES)) ? LINK_W'(NUM_PAGES) : total_ff;
   assign child     = ord_ff - ORD_W'(1);
   assign sp_ord    = span_of(ord_ff);
   assign sp_child  = span_of(child);
   assign sp_po     = span_of(po_ff);
   assign carve_o   = carve_order(cnt_ff, left_ff);
   assign sp_carve  = span_of(carve_o);
   assign mid       = cur_ff + sp_child[PAGE_W-1:0];
   assign bud       = cur_ff ^ sp_ord[PAGE_W-1:0];
   assign scan_addr = page_ff & align_mask(k_ff);
   assign so_q      = so_type'(so_rd);

   // lowest nonempty free list
   always_comb begin
      take_hit = 1'b0;
      take_o   = '0;
      for (int i = MAX_ORDER; i >= 0; i--) begin
         if (!lh_ff[i][LINK_W-1]) begin
            take_hit = 1'b1;
            take_o   = ORD_W'(i);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      act_in   = act_ff;
      page_in  = page_ff;
      cur_in   = cur_ff;
      ord_in   = ord_ff;
      addr_in  = addr_ff;
      k_in     = k_ff;
      cnt_in   = cnt_ff;
      left_in  = left_ff;
      x_in     = x_ff;
      po_in    = po_ff;
      hd_in    = hd_ff;
      free_in  = free_ff;
      fail_in  = fail_ff;
      pout_in  = pout_ff;
      lh_in    = lh_ff;
      so_we    = 1'b0;
      so_re    = 1'b0;
      so_addr  = '0;
      so_wdata = '0;
      nl_we    = 1'b0;
      nl_re    = 1'b0;
      nl_addr  = '0;
      nl_wdata = '0;
      pl_we    = 1'b0;
      pl_re    = 1'b0;
      pl_addr  = '0;
      pl_wdata = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_in  = req_action;
               page_in = req_page;
               fail_in = 1'b0;
               pout_in = '0;
               unique case (req_action)
                  ACT_INIT: begin
                     for (int i = 0; i <= MAX_ORDER; i++) lh_in[i] = NIL;
                     free_in  = '0;
                     cnt_in   = '0;
                     state_in = S_CLEAR;
                  end
                  ACT_ALLOC: state_in = S_TAKE;
                  ACT_FREE:  state_in = S_GIVE0;
                  default:   state_in = S_PIN0;
               endcase
            end
         end

         S_CLEAR: begin
            // wipe one status/order entry a cycle
            so_we   = 1'b1;
            so_addr = cnt_ff[PAGE_W-1:0];
            cnt_in  = cnt_ff + LINK_W'(1);
            if (cnt_ff[PAGE_W-1:0] == PAGE_W'(NUM_PAGES - 1)) begin
               if (act_ff == ACT_INIT) begin
                  cnt_in   = '0;
                  left_in  = pool;
                  state_in = S_CARVE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         S_CARVE: begin
            if (left_ff == '0) begin
               if (pool != '0) begin
                  page_in  = '0;
                  state_in = S_PIN0;
               end else begin
                  state_in = S_RESP;
               end
            end else begin
               x_in     = cnt_ff[PAGE_W-1:0];
               po_in    = carve_o;
               ret_in   = S_CARVE;
               cnt_in   = cnt_ff + sp_carve;
               left_in  = left_ff - sp_carve;
               state_in = S_PUSHA;
            end
         end

         S_PUSHA: begin
            // new head: mark free, link ahead of the old head
            so_we    = 1'b1;
            so_addr  = x_ff;
            so_wdata = '{st: ST_FREE, ord: po_ff};
            nl_we    = 1'b1;
            nl_addr  = x_ff;
            nl_wdata = lh_ff[po_ff];
            pl_we    = 1'b1;
            pl_addr  = x_ff;
            pl_wdata = NIL;
            hd_in    = lh_ff[po_ff];
            lh_in[po_ff] = {1'b0, x_ff};
            free_in  = free_ff + sp_po;
            state_in = S_PUSHB;
         end

         S_PUSHB: begin
            if (!hd_ff[LINK_W-1]) begin
               pl_we    = 1'b1;
               pl_addr  = hd_ff[PAGE_W-1:0];
               pl_wdata = {1'b0, x_ff};
            end
            state_in = ret_ff;
         end

         S_POPW: begin
            // unlink addr_ff; its links come from the read issued in S_TAKE, S_SCANR or S_MCHK
            if (!pl_q[LINK_W-1]) begin
               nl_we    = 1'b1;
               nl_addr  = pl_q[PAGE_W-1:0];
               nl_wdata = nl_q;
            end else begin
               lh_in[ord_ff] = nl_q;
            end
            if (!nl_q[LINK_W-1]) begin
               pl_we    = 1'b1;
               pl_addr  = nl_q[PAGE_W-1:0];
               pl_wdata = pl_q;
            end
            so_we   = 1'b1;
            so_addr = addr_ff;
            free_in = free_ff - sp_ord;
            unique case (act_ff)
               ACT_ALLOC: state_in = S_TSPLIT;
               ACT_FREE: begin
                  cur_in   = (addr_ff < cur_ff) ? addr_ff : cur_ff;
                  ord_in   = ord_ff + ORD_W'(1);
                  state_in = S_MCHK;
               end
               default: state_in = S_SPLIT;
            endcase
         end

         S_PIN0: begin
            if ({1'b0, page_ff} >= pool) begin
               fail_in  = 1'b1;
               state_in = S_RESP;
            end else begin
               k_in     = '0;
               state_in = S_SCANR;
            end
         end

         S_SCANR: begin
            // probe the aligned candidate head at level k
            addr_in  = scan_addr;
            so_re    = 1'b1;
            so_addr  = scan_addr;
            nl_re    = 1'b1;
            nl_addr  = scan_addr;
            pl_re    = 1'b1;
            pl_addr  = scan_addr;
            state_in = S_SCAND;
         end

         S_SCAND: begin
            if (so_q.st != ST_UNUSED && so_q.ord == k_ff) begin
               cur_in = addr_ff;
               ord_in = so_q.ord;
               priority if (so_q.st == ST_RESV) begin
                  state_in = S_RESP;
               end else if (so_q.st == ST_FREE) begin
                  state_in = S_POPW;
               end else begin
                  fail_in  = 1'b1;
                  state_in = S_RESP;
               end
            end else if (k_ff == ORD_W'(MAX_ORDER)) begin
               fail_in  = 1'b1;
               state_in = S_RESP;
            end else begin
               k_in     = k_ff + ORD_W'(1);
               state_in = S_SCANR;
            end
         end

         S_SPLIT: begin
            // halve toward the pinned page, free the other half
            if (ord_ff == '0) begin
               so_we    = 1'b1;
               so_addr  = cur_ff;
               so_wdata = '{st: ST_RESV, ord: '0};
               state_in = S_RESP;
            end else begin
               po_in  = child;
               ord_in = child;
               ret_in = S_SPLIT;
               if (page_ff < mid) begin
                  x_in = mid;
               end else begin
                  x_in   = cur_ff;
                  cur_in = mid;
               end
               state_in = S_PUSHA;
            end
         end

         S_TAKE: begin
            if (!take_hit) begin
               fail_in  = 1'b1;
               state_in = S_RESP;
            end else begin
               cur_in   = lh_ff[take_o][PAGE_W-1:0];
               addr_in  = lh_ff[take_o][PAGE_W-1:0];
               ord_in   = take_o;
               nl_re    = 1'b1;
               nl_addr  = lh_ff[take_o][PAGE_W-1:0];
               pl_re    = 1'b1;
               pl_addr  = lh_ff[take_o][PAGE_W-1:0];
               state_in = S_POPW;
            end
         end

         S_TSPLIT: begin
            // keep the low half, free the upper half
            if (ord_ff == '0) begin
               so_we    = 1'b1;
               so_addr  = cur_ff;
               so_wdata = '{st: ST_ALLOC, ord: '0};
               pout_in  = cur_ff;
               state_in = S_RESP;
            end else begin
               ord_in   = child;
               po_in    = child;
               x_in     = mid;
               ret_in   = S_TSPLIT;
               state_in = S_PUSHA;
            end
         end

         S_GIVE0: begin
            if ({1'b0, page_ff} >= pool) begin
               fail_in  = 1'b1;
               state_in = S_RESP;
            end else begin
               so_re    = 1'b1;
               so_addr  = page_ff;
               state_in = S_GIVE1;
            end
         end

         S_GIVE1: begin
            if (so_q.st == ST_ALLOC && so_q.ord == '0) begin
               so_we    = 1'b1;
               so_addr  = page_ff;
               cur_in   = page_ff;
               ord_in   = '0;
               state_in = S_MCHK;
            end else begin
               fail_in  = 1'b1;
               state_in = S_RESP;
            end
         end

         S_MCHK: begin
            if (ord_ff == ORD_W'(MAX_ORDER) || {1'b0, bud} >= pool) begin
               x_in     = cur_ff;
               po_in    = ord_ff;
               ret_in   = S_RESP;
               state_in = S_PUSHA;
            end else begin
               addr_in  = bud;
               so_re    = 1'b1;
               so_addr  = bud;
               nl_re    = 1'b1;
               nl_addr  = bud;
               pl_re    = 1'b1;
               pl_addr  = bud;
               state_in = S_MCHD;
            end
         end

         S_MCHD: begin
            if (so_q.st == ST_FREE && so_q.ord == ord_ff) begin
               state_in = S_POPW;
            end else begin
               x_in     = cur_ff;
               po_in    = ord_ff;
               ret_in   = S_RESP;
               state_in = S_PUSHA;
            end
         end

         S_RESP: state_in = S_IDLE;

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         act_ff   <= ACT_ALLOC;
         cnt_ff   <= '0;
         free_ff  <= '0;
         total_ff <= '0;
         for (int i = 0; i <= MAX_ORDER; i++) lh_ff[i] <= NIL;
      end else begin
         state_ff <= state_in;
         act_ff   <= act_in;
         cnt_ff   <= cnt_in;
         free_ff  <= free_in;
         lh_ff    <= lh_in;
         if (csr_valid) total_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff  <= ret_in;
      page_ff <= page_in;
      cur_ff  <= cur_in;
      ord_ff  <= ord_in;
      addr_ff <= addr_in;
      k_ff    <= k_in;
      left_ff <= left_in;
      x_ff    <= x_in;
      po_ff   <= po_in;
      hd_ff   <= hd_in;
      fail_ff <= fail_in;
      pout_ff <= pout_in;
   end

   bpa_ram #(.WIDTH($bits(so_type)), .DEPTH(NUM_PAGES)) u_so (
      .clock (clock),
      .we    (so_we),
      .re    (so_re),
      .addr  (so_addr),
      .wdata (so_wdata),
      .rdata (so_rd)
   );

   bpa_ram #(.WIDTH(LINK_W), .DEPTH(NUM_PAGES)) u_next (
      .clock (clock),
      .we    (nl_we),
      .re    (nl_re),
      .addr  (nl_addr),
      .wdata (nl_wdata),
      .rdata (nl_q)
   );

   bpa_ram #(.WIDTH(LINK_W), .DEPTH(NUM_PAGES)) u_prev (
      .clock (clock),
      .we    (pl_we),
      .re    (pl_re),
      .addr  (pl_addr),
      .wdata (pl_wdata),
      .rdata (pl_q)
   );

   assign busy           = (state_ff != S_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = (state_ff == S_RESP);
   assign rsp_status     = fail_ff && (act_ff != ACT_INIT);
   assign rsp_page_out   = pout_ff;
   assign rsp_free_count = free_ff;

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken but sequencer did not leave idle");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= LINK_W'(NUM_PAGES))
      else $error("free page count above pool size");

   a_alloc_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && act_ff == ACT_ALLOC && rsp_status) |-> (rsp_page_out == '0))
      else $error("failed allocate returned a page");

endmodule

// File: test/tb_buddy_page_allocator.sv
// Self-checking testbench for buddy_page_allocator: drives init, allocate, free and
// reserve requests, predicts each response with an in-bench buddy model.
// Depends on bpa_pkg and the RTL of buddy_page_allocator.
import bpa_pkg::*;

class pool_scoreboard;
   // in-bench copy of the allocator state
   int unsigned heads[MAX_ORDER+1];
   int unsigned nxt[NUM_PAGES];
   int unsigned prv[NUM_PAGES];
   int unsigned owner[NUM_PAGES];
   logic [ST_W-1:0] stat[NUM_PAGES];
   int unsigned ord_of[NUM_PAGES];
   int unsigned free_pages;
   int unsigned pool_reg;
   int errors;
   logic [1:0] exp_status[$];
   logic [PAGE_W-1:0] exp_page[$];
   logic [LINK_W-1:0] exp_free[$];

   function void wipe();
      for (int i = 0; i <= MAX_ORDER; i++) heads[i] = NUM_PAGES;
      for (int i = 0; i < NUM_PAGES; i++) begin
         nxt[i] = NUM_PAGES; prv[i] = NUM_PAGES; owner[i] = NUM_PAGES;
         stat[i] = ST_UNUSED; ord_of[i] = 0;
      end
      free_pages = 0;
   endfunction

   function int unsigned pool_size();
      return (pool_reg > NUM_PAGES) ? NUM_PAGES : pool_reg;
   endfunction

   function void mark(int unsigned s, int unsigned o, logic [ST_W-1:0] st);
      if (s >= NUM_PAGES) return;
      for (int unsigned i = 0; i < (1 << o) && s + i < NUM_PAGES; i++) owner[s+i] = s;
      ord_of[s] = o;
      stat[s] = st;
   endfunction

   function void unmark(int unsigned s);
      ord_of[s] = 0; stat[s] = ST_UNUSED;
   endfunction

   function void link_in(int unsigned s, int unsigned o);
      int unsigned h;
      mark(s, o, ST_FREE);
      h = heads[o];
      prv[s] = NUM_PAGES; nxt[s] = h;
      if (h < NUM_PAGES) prv[h] = s;
      heads[o] = s;
      free_pages += 1 << o;
   endfunction

   function void unlink(int unsigned s);
      int unsigned o, p, n;
      o = ord_of[s]; p = prv[s]; n = nxt[s];
      if (p < NUM_PAGES) nxt[p] = n; else heads[o] = n;
      if (n < NUM_PAGES) prv[n] = p;
      prv[s] = NUM_PAGES; nxt[s] = NUM_PAGES;
      free_pages -= 1 << o;
      unmark(s);
   endfunction

   function bit pin(int unsigned pg);
      int unsigned h, cur, o, mid;
      if (pg >= pool_size()) return 0;
      h = owner[pg];
      if (h >= NUM_PAGES) return 0;
      if (stat[h] == ST_RESV) return 1;
      if (stat[h] != ST_FREE) return 0;
      cur = h; o = ord_of[h];
      unlink(h);
      while (o > 0) begin
         mid = cur + (1 << (o - 1));
         if (pg < mid) link_in(mid, o - 1);
         else begin
            link_in(cur, o - 1);
            cur = mid;
         end
         o--;
         mark(cur, o, ST_ALLOC);
      end
      mark(cur, 0, ST_RESV);
      return 1;
   endfunction

   function void build_pool();
      int unsigned tot, pg, left, o;
      tot = pool_size(); pg = 0; left = tot;
      wipe();
      while (left > 0) begin
         o = 0;
         while (o < MAX_ORDER && (1 << (o + 1)) <= left) o++;
         while (o > 0 && (pg & ((1 << o) - 1)) != 0) o--;
         link_in(pg, o);
         pg += 1 << o; left -= 1 << o;
      end
      if (tot > 0) void'(pin(0));
   endfunction

   function bit grab(output int unsigned got);
      int unsigned b;
      got = 0;
      for (int o = 0; o <= MAX_ORDER; o++) begin
         b = heads[o];
         if (b >= NUM_PAGES) continue;
         unlink(b);
         for (int k = o - 1; k >= 0; k--) link_in(b + (1 << k), k);
         mark(b, 0, ST_ALLOC);
         got = b;
         return 1;
      end
      return 0;
   endfunction

   function bit release_page(int unsigned pg);
      int unsigned tot, cur, o, bud;
      tot = pool_size(); cur = pg; o = 0;
      if (tot == 0 || pg >= tot) return 0;
      if (stat[pg] != ST_ALLOC || ord_of[pg] != 0) return 0;
      unmark(pg);
      mark(cur, 0, ST_FREE);
      while (o < MAX_ORDER) begin
         bud = cur ^ (1 << o);
         if (bud >= tot) break;
         if (stat[bud] != ST_FREE || ord_of[bud] != o) break;
         unlink(bud);
         unmark(cur); unmark(bud);
         if (bud < cur) cur = bud;
         o++;
         mark(cur, o, ST_FREE);
      end
      link_in(cur, o);
      return 1;
   endfunction

   // note an accepted request and queue its expected response
   function void note_request(logic [1:0] act, logic [PAGE_W-1:0] pg);
      int unsigned got;
      bit ok;
      got = 0;
      case (act)
         ACT_INIT: begin
            build_pool(); ok = 1;
         end
         ACT_ALLOC: ok = grab(got);
         ACT_FREE: ok = release_page(pg);
         default: ok = pin(pg);
      endcase
      exp_status.push_back(ok ? 0 : 1);
      exp_page.push_back(PAGE_W'(got));
      exp_free.push_back(LINK_W'(free_pages));
   endfunction

   function void check_response(logic st, logic [PAGE_W-1:0] pg, logic [LINK_W-1:0] fc);
      logic [1:0] es;
      if (exp_status.size() == 0) begin
         $error("response with nothing outstanding");
         errors++;
         return;
      end
      es = exp_status.pop_front();
      if (st !== es[0]) begin
         $error("status: expected %0d, got %0d", es[0], st); errors++;
      end
      if (pg !== exp_page[0]) begin
         $error("page_out: expected %0d, got %0d", exp_page[0], pg); errors++;
      end
      if (fc !== exp_free[0]) begin
         $error("free_count: expected %0d, got %0d", exp_free[0], fc); errors++;
      end
      void'(exp_page.pop_front());
      void'(exp_free.pop_front());
   endfunction
endclass

module tb_buddy_page_allocator;
   logic clock, reset, start, busy;
   logic [1:0] req_action;
   logic [PAGE_W-1:0] req_page;
   logic rsp_valid, rsp_status;
   logic [PAGE_W-1:0] rsp_page_out;
   logic [LINK_W-1:0] rsp_free_count;
   logic csr_valid, csr_ready;
   logic [LINK_W-1:0] csr_wdata;

   pool_scoreboard pool;
   int unsigned idle_cycles;
   int burst_left;
   int unsigned live_pages[$];

   localparam int unsigned STALL_LIMIT = 40000;

   buddy_page_allocator DUT (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // check every response strobe; count cycles with no handshake for the watchdog
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         pool.check_response(rsp_status, rsp_page_out, rsp_free_count);
      end
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   always @(posedge clock) begin
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_buddy_page_allocator: done, errors");
         $finish;
      end
   end

   // send one request; hold start until the block takes it
   task automatic send_request(logic [1:0] act, logic [PAGE_W-1:0] pg);
      if (burst_left <= 0) begin
         // gap between bursts
         repeat ($urandom_range(0, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 8);
      end
      start <= 1; req_action <= act; req_page <= pg;
      @(posedge clock);
      while (busy) @(posedge clock);
      pool.note_request(act, pg);
      if (act == ACT_ALLOC && pool.exp_status[$] == 0)
         live_pages.push_back(pool.exp_page[$]);
      burst_left--;
      start <= 0;
      // the block is busy now; step past this edge before the next drive
      @(posedge clock);
   endtask

   // drain, let the block settle, then write the pool size
   task automatic set_pool_size(logic [LINK_W-1:0] n);
      while (pool.exp_status.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      csr_valid <= 1; csr_wdata <= n;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      pool.pool_reg = n;
   endtask

   task automatic random_phase(int count);
      int unsigned r, pg, k;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 45) send_request(ACT_ALLOC, PAGE_W'($urandom));
         else if (r < 80 && live_pages.size() > 0) begin
            // mostly free a page we hold; sometimes a random one
            k = $urandom_range(0, live_pages.size() - 1);
            pg = live_pages[k];
            live_pages.delete(k);
            send_request(ACT_FREE, PAGE_W'(pg));
         end else if (r < 85) send_request(ACT_FREE, PAGE_W'($urandom));
         else if (r < 97) send_request(ACT_RESV,
                                       PAGE_W'($urandom_range(0, pool.pool_size() + 3)));
         else begin
            live_pages.delete();
            send_request(ACT_INIT, PAGE_W'($urandom));
         end
      end
   endtask

   initial begin
      pool = new();
      pool.wipe();
      pool.pool_reg = 0;
      pool.errors = 0;
      idle_cycles = 0;
      burst_left = 0;
      reset = 1; start = 0; req_action = ACT_INIT; req_page = '0;
      csr_valid = 0; csr_wdata = '0;
      repeat (9) @(posedge clock);
      reset <= 0;

      // empty pool: init, then every operation fails
      send_request(ACT_INIT, '0);
      send_request(ACT_ALLOC, '0);
      send_request(ACT_FREE, '0);
      send_request(ACT_RESV, '0);

      // small odd pool: exhaust, refuse, bad frees, reserve cases
      set_pool_size(13);
      live_pages.delete();
      send_request(ACT_INIT, 12'hFFF);
      for (int i = 0; i < 13; i++) send_request(ACT_ALLOC, '0);
      send_request(ACT_FREE, 12'd0);
      send_request(ACT_FREE, 12'd13);
      send_request(ACT_FREE, 12'hFFF);
      send_request(ACT_FREE, 12'd5);
      send_request(ACT_FREE, 12'd5);
      send_request(ACT_RESV, 12'd5);
      send_request(ACT_RESV, 12'd0);
      send_request(ACT_RESV, 12'd6);
      send_request(ACT_RESV, 12'd13);
      live_pages.delete();

      set_pool_size(40);
      send_request(ACT_INIT, '0);
      random_phase(20);

      // pool wider than the store: clamped to the full size
      set_pool_size(13'h1FFF);
      live_pages.delete();
      send_request(ACT_INIT, '0);
      send_request(ACT_RESV, 12'hFFF);
      send_request(ACT_RESV, 12'hAAA);
      send_request(ACT_RESV, 12'h555);
      random_phase(30);

      set_pool_size(4096);
      live_pages.delete();
      send_request(ACT_INIT, '0);
      random_phase(20);

      // shrink without re-init: bound checks use the new size at once
      set_pool_size(2);
      random_phase(20);
      send_request(ACT_INIT, '0);
      random_phase(20);

      while (pool.exp_status.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (pool.errors == 0)
         $display("tb_buddy_page_allocator: done, clean");
      else
         $display("tb_buddy_page_allocator: done, errors");
      $finish;
   end
endmodule

// File: sim.f
rtl/bpa_pkg.sv
rtl/bpa_ram.sv
rtl/buddy_page_allocator.sv
test/tb_buddy_page_allocator.sv
